// ===== src/ghv_pkg.sv =====
// Shared types, constants and the CRC byte update for the GPT header validator.
package ghv_pkg;

	// Signature bytes "EFI PART", offset 0 upwards
	localparam logic [7:0] SIG_BYTES [8] = '{8'h45, 8'h46, 8'h49, 8'h20,
		8'h50, 8'h41, 8'h52, 8'h54};

	localparam logic [31:0] REV_EXPECT   = 32'h0001_0000;
	localparam logic [31:0] RSVD_EXPECT  = 32'h0000_0000;
	localparam logic [63:0] MYLBA_EXPECT = 64'd1;
	localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

	// Byte offsets of the header fields
	localparam int OFS_REV   = 8;
	localparam int OFS_HSIZE = 12;
	localparam int OFS_HCRC  = 16;
	localparam int OFS_RSVD  = 20;
	localparam int OFS_MYLBA = 24;
	localparam int OFS_ELBA  = 72;
	localparam int OFS_ENUM  = 80;
	localparam int OFS_ESIZE = 84;
	localparam int OFS_ECRC  = 88;

	// Number of leading bytes whose running CRC is kept for short headers
	localparam int SNAP_DEPTH = 16;

	// What the front end hands over once a sector has been fully received
	typedef struct packed {
		logic        sig_match;
		logic        trailing_bad;
		logic [31:0] crc_sel;
		logic [31:0] rev;
		logic [31:0] hsize;
		logic [31:0] hcrc;
		logic [31:0] rsvd;
		logic [63:0] mylba;
		logic [63:0] elba;
		logic [31:0] enum_cnt;
		logic [31:0] esize;
		logic [31:0] ecrc;
	} summary_t;

	// Reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		end
		return r;
	endfunction

endpackage

// ===== src/ghv_front.sv =====
// Front end: takes sector bytes, runs the CRC and captures the header fields.
module ghv_front #(
	parameter int SECTOR_BYTES = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        data_byte,
	input  logic              data_valid,
	output logic              data_ready,
	input  logic              q_full,
	output logic              push,
	output ghv_pkg::summary_t sum
);
	import ghv_pkg::*;

	localparam int PW = $clog2(SECTOR_BYTES);
	localparam logic [PW-1:0] LAST_POS = PW'(SECTOR_BYTES - 1);

	logic [PW-1:0] pos_q;
	logic [31:0]   crc_q;
	logic [31:0]   crc_len_q;
	logic [31:0]   snap_q [SNAP_DEPTH];
	logic          sig_q;
	logic          seen_q;
	logic [PW-1:0] hi_q;
	logic [31:0]   rev_q, hsize_q, hcrc_q, rsvd_q, enum_q, esize_q, ecrc_q;
	logic [63:0]   mylba_q, elba_q;

	logic          acc;
	logic          first;
	logic [31:0]   crc_cur;
	logic [31:0]   crc_next;
	logic [7:0]    feed;
	logic          sig_next;
	logic          seen_next;
	logic [PW-1:0] hi_next;
	logic [31:0]   hs_now;
	logic          len_hit;

	assign data_ready = !q_full;
	assign acc        = data_valid && data_ready;
	assign first      = (pos_q == '0);

	// Per-sector state restarts at offset 0
	always_comb begin
		crc_cur = first ? CRC_INIT : crc_q;
		feed = (pos_q >= PW'(OFS_HCRC) && pos_q < PW'(OFS_HCRC + 4)) ? 8'h00 : data_byte;
		crc_next = crc_byte(crc_cur, feed);
		sig_next = first ? 1'b1 : sig_q;
		if (pos_q < PW'(8) && data_byte != SIG_BYTES[pos_q[2:0]]) begin
			sig_next = 1'b0;
		end
		seen_next = (first ? 1'b0 : seen_q) | (data_byte != 8'h00);
		hi_next = (data_byte != 8'h00) ? pos_q : hi_q;
	end

	// Header size including the byte arriving now (top byte lands at offset 15)
	always_comb begin
		hs_now = (pos_q == PW'(OFS_HSIZE + 3)) ? {data_byte, hsize_q[23:0]} : hsize_q;
		if (hs_now > 32'(SECTOR_BYTES)) begin
			len_hit = (pos_q == LAST_POS);
		end else begin
			len_hit = (pos_q >= PW'(OFS_HSIZE + 3)) && ((32'(pos_q) + 32'd1) == hs_now);
		end
	end

	// Position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (acc) begin
			pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + PW'(1);
		end
	end

	// Running checks, CRC snapshots and field capture
	always_ff @(posedge clk) begin
		if (acc) begin
			crc_q  <= crc_next;
			sig_q  <= sig_next;
			seen_q <= seen_next;
			hi_q   <= hi_next;
			if (pos_q < PW'(SNAP_DEPTH)) begin
				snap_q[pos_q[3:0]] <= crc_cur;
			end
			// Short headers take their CRC from the prefix snapshot once the size is known
			if (pos_q == PW'(SNAP_DEPTH) && hsize_q < 32'(SNAP_DEPTH)) begin
				crc_len_q <= snap_q[hsize_q[3:0]];
			end else if (len_hit) begin
				crc_len_q <= crc_next;
			end
			for (int i = 0; i < 4; i++) begin
				if (pos_q == PW'(OFS_REV + i))   rev_q[8*i +: 8]   <= data_byte;
				if (pos_q == PW'(OFS_HSIZE + i)) hsize_q[8*i +: 8] <= data_byte;
				if (pos_q == PW'(OFS_HCRC + i))  hcrc_q[8*i +: 8]  <= data_byte;
				if (pos_q == PW'(OFS_RSVD + i))  rsvd_q[8*i +: 8]  <= data_byte;
				if (pos_q == PW'(OFS_ENUM + i))  enum_q[8*i +: 8]  <= data_byte;
				if (pos_q == PW'(OFS_ESIZE + i)) esize_q[8*i +: 8] <= data_byte;
				if (pos_q == PW'(OFS_ECRC + i))  ecrc_q[8*i +: 8]  <= data_byte;
			end
			for (int i = 0; i < 8; i++) begin
				if (pos_q == PW'(OFS_MYLBA + i)) mylba_q[8*i +: 8] <= data_byte;
				if (pos_q == PW'(OFS_ELBA + i))  elba_q[8*i +: 8]  <= data_byte;
			end
		end
	end

	// Sector summary, pushed with the last byte
	always_comb begin
		push = acc && (pos_q == LAST_POS);
		sum.sig_match = sig_next;
		sum.trailing_bad = (hsize_q > 32'(SECTOR_BYTES)) ||
			(seen_next && (32'(hi_next) >= hsize_q));
		if (hsize_q >= 32'(SECTOR_BYTES)) begin
			sum.crc_sel = crc_next;
		end else begin
			sum.crc_sel = crc_len_q;
		end
		sum.rev      = rev_q;
		sum.hsize    = hsize_q;
		sum.hcrc     = hcrc_q;
		sum.rsvd     = rsvd_q;
		sum.mylba    = mylba_q;
		sum.elba     = elba_q;
		sum.enum_cnt = enum_q;
		sum.esize    = esize_q;
		sum.ecrc     = ecrc_q;
	end

	// Counter wraps to offset 0 after the last byte
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (pos_q == '0))
		else $error("position did not wrap after last byte");

endmodule

// ===== src/ghv_queue.sv =====
// Two-entry queue of sector summaries between front and back ends.
module ghv_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ghv_pkg::summary_t wr_data,
	input  logic              pop,
	output ghv_pkg::summary_t rd_data,
	output logic              full,
	output logic              empty
);
	import ghv_pkg::*;

	summary_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("summary queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("summary queue underflow");

endmodule

// ===== src/ghv_back.sv =====
// Back end: evaluates the header checks and holds the result item.
module ghv_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ghv_pkg::summary_t head,
	input  logic              q_empty,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_ready,
	output logic              header_ok,
	output logic              signature_bad,
	output logic              revision_bad,
	output logic              reserved_bad,
	output logic              self_lba_bad,
	output logic              trailing_bad,
	output logic              checksum_bad,
	output logic [31:0]       header_length,
	output logic [63:0]       entry_start_lba,
	output logic [31:0]       entry_total,
	output logic [31:0]       entry_bytes,
	output logic [31:0]       entry_array_checksum
);
	import ghv_pkg::*;

	logic valid_q;
	logic sig_b, rev_b, rsv_b, lba_b, crc_b;

	// Checks on the queue head
	always_comb begin
		sig_b = !head.sig_match;
		rev_b = (head.rev != REV_EXPECT);
		rsv_b = (head.rsvd != RSVD_EXPECT);
		lba_b = (head.mylba != MYLBA_EXPECT);
		crc_b = (head.hcrc != ~head.crc_sel);
	end

	assign pop          = !q_empty && (!valid_q || result_ready);
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (pop) begin
			signature_bad        <= sig_b;
			revision_bad         <= rev_b;
			reserved_bad         <= rsv_b;
			self_lba_bad         <= lba_b;
			trailing_bad         <= head.trailing_bad;
			checksum_bad         <= crc_b;
			header_ok            <= !(sig_b || rev_b || rsv_b || lba_b ||
				head.trailing_bad || crc_b);
			header_length        <= head.hsize;
			entry_start_lba      <= head.elba;
			entry_total          <= head.enum_cnt;
			entry_bytes          <= head.esize;
			entry_array_checksum <= head.ecrc;
		end
	end

	a_ok_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (header_ok == !(signature_bad || revision_bad || reserved_bad ||
			self_lba_bad || trailing_bad || checksum_bad)))
		else $error("header_ok inconsistent with error flags");

endmodule

// ===== src/gpt_header_validator.sv =====
// Top level of the GPT header validator.
//
// Input channel: one header sector byte per item (data_byte, data_valid,
// data_ready), offsets 0 to SECTOR_BYTES-1 in order. A new sector starts
// straight after the last byte of the previous one.
// Result channel: one item per sector (result_valid, result_ready) carrying
// the six check flags, header_ok and the partition entry array fields.
// Throughput: one byte per cycle while data_ready is high; the CRC-32 byte update
// and the field capture in the front end keep pace with each accepted byte.
// The result item turns valid once the last byte of a sector has been written
// into the summary queue and then taken from there into the output register,
// provided the output register is free.
// A two-entry summary queue sits between front and back ends, so bytes keep
// flowing while a result waits; data_ready drops only when two finished
// summaries are queued.
// Reset: all control state clears, the byte position returns to offset 0
// and no result is pending. There is no clearing pass.
module gpt_header_validator #(
	parameter int SECTOR_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        data_valid,
	output logic        data_ready,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        header_ok,
	output logic        signature_bad,
	output logic        revision_bad,
	output logic        reserved_bad,
	output logic        self_lba_bad,
	output logic        trailing_bad,
	output logic        checksum_bad,
	output logic [31:0] header_length,
	output logic [63:0] entry_start_lba,
	output logic [31:0] entry_total,
	output logic [31:0] entry_bytes,
	output logic [31:0] entry_array_checksum
);
	import ghv_pkg::*;

	summary_t sum_in;
	summary_t sum_head;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_empty;

	ghv_front #(.SECTOR_BYTES(SECTOR_BYTES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.q_full     (q_full),
		.push       (push),
		.sum        (sum_in)
	);

	ghv_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (sum_in),
		.pop     (pop),
		.rd_data (sum_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	ghv_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.head                 (sum_head),
		.q_empty              (q_empty),
		.pop                  (pop),
		.result_valid         (result_valid),
		.result_ready         (result_ready),
		.header_ok            (header_ok),
		.signature_bad        (signature_bad),
		.revision_bad         (revision_bad),
		.reserved_bad         (reserved_bad),
		.self_lba_bad         (self_lba_bad),
		.trailing_bad         (trailing_bad),
		.checksum_bad         (checksum_bad),
		.header_length        (header_length),
		.entry_start_lba      (entry_start_lba),
		.entry_total          (entry_total),
		.entry_bytes          (entry_bytes),
		.entry_array_checksum (entry_array_checksum)
	);

endmodule

// ===== tb/gpt_header_validator_tb.sv =====
// Self-checking testbench for the GPT header validator: byte stream in, one verdict per sector.
module gpt_header_validator_tb;
	import ghv_pkg::*;

	localparam int SECTOR     = 512;
	localparam int HOLD_LEN   = 4000;
	localparam int CYCLE_CAP  = 1_000_000;
	localparam int RAND_SECTS = 40;

	// Header faults that the stimulus can plant
	typedef enum int {
		FLT_NONE, FLT_SIG, FLT_REV, FLT_RSVD, FLT_LBA, FLT_TRAIL, FLT_CRC
	} fault_t;

	// One verdict as it leaves the block
	typedef struct packed {
		logic        ok;
		logic        sig_bad;
		logic        rev_bad;
		logic        rsvd_bad;
		logic        lba_bad;
		logic        trail_bad;
		logic        crc_bad;
		logic [31:0] hlen;
		logic [63:0] elba;
		logic [31:0] etotal;
		logic [31:0] ebytes;
		logic [31:0] ecrc;
	} verdict_t;

	// One byte to send; wait_idle holds it back until every verdict is in
	typedef struct packed {
		logic [7:0] b;
		logic       wait_idle;
	} feed_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        data_valid = 1'b0;
	logic        data_ready;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        header_ok;
	logic        signature_bad;
	logic        revision_bad;
	logic        reserved_bad;
	logic        self_lba_bad;
	logic        trailing_bad;
	logic        checksum_bad;
	logic [31:0] header_length;
	logic [63:0] entry_start_lba;
	logic [31:0] entry_total;
	logic [31:0] entry_bytes;
	logic [31:0] entry_array_checksum;

	feed_t    byte_feed[$];
	verdict_t verdicts_due[$];
	logic [7:0] hdr [SECTOR];
	logic [7:0] sector_buf [SECTOR];
	int       sector_pos = 0;
	int       bytes_taken = 0;
	int       sectors_built = 0;
	int       passing_due = 0;
	int       results_seen = 0;
	int       mismatches = 0;
	int       in_stall_cycles = 0;
	int       out_stall_cycles = 0;
	int       burst_left = 0;
	int       gap_left = 0;
	logic       nxt_valid;
	logic [7:0] nxt_byte;
	int       hold_cycles = 0;
	logic     hold_done = 1'b0;
	logic [15:0] stall_pat = 16'hFFFF;
	int       pat_idx = 0;
	int       pat_age = 0;
	verdict_t want_v;
	verdict_t got_v;

	gpt_header_validator u_top (
		.clk                  (clk),
		.arst_n               (arst_n),
		.data_byte            (data_byte),
		.data_valid           (data_valid),
		.data_ready           (data_ready),
		.result_valid         (result_valid),
		.result_ready         (result_ready),
		.header_ok            (header_ok),
		.signature_bad        (signature_bad),
		.revision_bad         (revision_bad),
		.reserved_bad         (reserved_bad),
		.self_lba_bad         (self_lba_bad),
		.trailing_bad         (trailing_bad),
		.checksum_bad         (checksum_bad),
		.header_length        (header_length),
		.entry_start_lba      (entry_start_lba),
		.entry_total          (entry_total),
		.entry_bytes          (entry_bytes),
		.entry_array_checksum (entry_array_checksum)
	);

	always #5 clk = ~clk;

	// Reflected CRC-32, one data bit at a time
	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		for (int j = 0; j < 8; j++) begin
			if (c[0] ^ b[j])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	function automatic logic [31:0] nz32();
		return $urandom | (32'h1 << $urandom_range(0, 31));
	endfunction

	// Little-endian field from the received sector
	function automatic logic [63:0] sect_le(input int ofs, input int n);
		logic [63:0] v;
		v = '0;
		for (int k = 0; k < n; k++)
			v[8*k +: 8] = sector_buf[ofs + k];
		return v;
	endfunction

	// Verdict for a complete sector held in sector_buf
	function automatic verdict_t judge_sector();
		verdict_t    v;
		logic [31:0] hs;
		logic [31:0] crc;
		logic [63:0] stored;
		int          span;
		v.sig_bad = 1'b0;
		for (int i = 0; i < 8; i++)
			if (sector_buf[i] != SIG_BYTES[i])
				v.sig_bad = 1'b1;
		hs = 32'(sect_le(OFS_HSIZE, 4));
		span = (hs > SECTOR) ? SECTOR : int'(hs);
		// CRC field itself counts as zero
		crc = CRC_INIT;
		for (int i = 0; i < span; i++)
			crc = crc_step(crc, (i >= OFS_HCRC && i < OFS_HCRC + 4) ? 8'h00 : sector_buf[i]);
		v.trail_bad = hs > SECTOR;
		for (int i = 0; i < SECTOR; i++)
			if (sector_buf[i] != 8'h00 && 32'(i) >= hs)
				v.trail_bad = 1'b1;
		stored = sect_le(OFS_HCRC, 4);
		v.rev_bad  = sect_le(OFS_REV, 4) != 64'(REV_EXPECT);
		v.rsvd_bad = sect_le(OFS_RSVD, 4) != 64'(RSVD_EXPECT);
		v.lba_bad  = sect_le(OFS_MYLBA, 8) != MYLBA_EXPECT;
		v.crc_bad  = stored[31:0] != ~crc;
		v.ok = !(v.sig_bad || v.rev_bad || v.rsvd_bad || v.lba_bad || v.trail_bad
			|| v.crc_bad);
		v.hlen   = hs;
		v.elba   = sect_le(OFS_ELBA, 8);
		v.etotal = 32'(sect_le(OFS_ENUM, 4));
		v.ebytes = 32'(sect_le(OFS_ESIZE, 4));
		v.ecrc   = 32'(sect_le(OFS_ECRC, 4));
		return v;
	endfunction

	// Collect one accepted byte; a full sector yields its verdict
	task automatic absorb_byte(input logic [7:0] b);
		verdict_t v;
		sector_buf[sector_pos] = b;
		bytes_taken++;
		if (sector_pos == SECTOR - 1) begin
			v = judge_sector();
			if (v.ok)
				passing_due++;
			verdicts_due.push_back(v);
			sector_pos = 0;
		end else begin
			sector_pos++;
		end
	endtask

	task automatic put_le(input int ofs, input int n, input logic [63:0] v);
		for (int k = 0; k < n; k++)
			hdr[ofs + k] = v[8*k +: 8];
	endtask

	// Store the correct header CRC for whatever hdr now holds
	task automatic seal_crc();
		logic [31:0] hs;
		logic [31:0] c;
		int          span;
		put_le(OFS_HCRC, 4, 64'd0);
		hs = {hdr[15], hdr[14], hdr[13], hdr[12]};
		span = (hs > SECTOR) ? SECTOR : int'(hs);
		c = CRC_INIT;
		for (int i = 0; i < span; i++)
			c = crc_step(c, hdr[i]);
		put_le(OFS_HCRC, 4, 64'(~c));
	endtask

	// Well-formed header with random content, then at most one planted fault
	task automatic make_header(input logic [31:0] hs, input fault_t fault);
		int span;
		for (int i = 0; i < SECTOR; i++)
			hdr[i] = 8'h00;
		for (int i = 0; i < 8; i++)
			hdr[i] = SIG_BYTES[i];
		put_le(OFS_REV, 4, 64'(REV_EXPECT));
		put_le(OFS_HSIZE, 4, 64'(hs));
		put_le(OFS_MYLBA, 8, MYLBA_EXPECT);
		put_le(OFS_ELBA, 8, {$urandom, $urandom});
		put_le(OFS_ENUM, 4, 64'($urandom));
		put_le(OFS_ESIZE, 4, 64'($urandom));
		put_le(OFS_ECRC, 4, 64'($urandom));
		span = (hs > SECTOR) ? SECTOR : int'(hs);
		for (int i = 32; i < OFS_ELBA; i++)
			hdr[i] = 8'($urandom_range(0, 255));
		for (int i = OFS_ECRC + 4; i < span; i++)
			hdr[i] = 8'($urandom_range(0, 255));
		case (fault)
			FLT_SIG: begin
				hdr[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
			end
			FLT_REV: begin
				put_le(OFS_REV, 4, 64'(REV_EXPECT ^ nz32()));
			end
			FLT_RSVD: begin
				put_le(OFS_RSVD, 4, 64'(nz32()));
			end
			FLT_LBA: begin
				put_le(OFS_MYLBA, 8, MYLBA_EXPECT ^ {$urandom, nz32()});
			end
			FLT_TRAIL: begin
				if (hs < SECTOR)
					hdr[$urandom_range(int'(hs), SECTOR - 1)] = 8'($urandom_range(1, 255));
				else
					put_le(OFS_HSIZE, 4, 64'(SECTOR + $urandom_range(1, 4096)));
			end
			default: ;
		endcase
		seal_crc();
		if (fault == FLT_CRC)
			hdr[OFS_HCRC + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
	endtask

	task automatic queue_sector(input logic wait_idle);
		feed_t f;
		for (int i = 0; i < SECTOR; i++) begin
			f.b = hdr[i];
			f.wait_idle = wait_idle && (i == 0);
			byte_feed.push_back(f);
		end
		sectors_built++;
	endtask

	// The usual 92-byte header half the time, with short, full and oversized lengths mixed in
	function automatic logic [31:0] pick_length();
		case ($urandom_range(0, 7))
			0, 1, 2, 3: return 32'd92;
			4: return 32'($urandom_range(92, SECTOR));
			5: return 32'($urandom_range(0, 91));
			6: return 32'(SECTOR);
			default: return ($urandom_range(0, 1) != 0) ? 32'($urandom_range(513, 2000))
				: $urandom;
		endcase
	endfunction

	task automatic note_field(input string what, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("verdict %0d: %s expected %h, got %h", results_seen, what, want, got);
		end
	endtask

	// Sender: bursts of items with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_valid <= 1'b0;
			data_byte  <= 8'h00;
			burst_left = $urandom_range(1, 64);
			gap_left   = 0;
		end else begin
			if (data_valid && data_ready)
				absorb_byte(data_byte);
			if (!data_valid || data_ready) begin
				nxt_valid = 1'b0;
				nxt_byte  = data_byte;
				if (gap_left > 0) begin
					gap_left--;
				end else if (byte_feed.size() != 0
					&& !(byte_feed[0].wait_idle && verdicts_due.size() != 0)) begin
					nxt_byte  = byte_feed[0].b;
					nxt_valid = 1'b1;
					void'(byte_feed.pop_front());
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 64);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				data_valid <= nxt_valid;
				data_byte  <= nxt_byte;
			end
		end
	end

	// One long receiver hold-off once a few verdicts have come back
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
			hold_done   <= 1'b0;
		end else if (!hold_done && results_seen >= 5) begin
			hold_cycles <= HOLD_LEN;
			hold_done   <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// Receiver: a rotating ready pattern, re-drawn every so often
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_pat = 16'hFFFF;
			pat_idx   = 0;
			pat_age   = 0;
		end else begin
			if (pat_age == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pat = 16'hFFFF;
					1: stall_pat = 16'($urandom);
					2: stall_pat = 16'($urandom & $urandom & $urandom);
					default: stall_pat = 16'($urandom | $urandom);
				endcase
				pat_age = $urandom_range(16, 200);
			end else begin
				pat_age--;
			end
			result_ready <= (hold_cycles == 0) && stall_pat[pat_idx];
			pat_idx = (pat_idx + 1) % 16;
		end
	end

	// Result check against the oldest verdict due
	always @(posedge clk) begin
		if (arst_n) begin
			if (data_valid && !data_ready)
				in_stall_cycles++;
			if (result_valid && !result_ready)
				out_stall_cycles++;
			if (result_valid && result_ready) begin
				got_v = '{header_ok, signature_bad, revision_bad, reserved_bad, self_lba_bad,
					trailing_bad, checksum_bad, header_length, entry_start_lba, entry_total,
					entry_bytes, entry_array_checksum};
				if (verdicts_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("verdict %0d arrived with none due", results_seen);
				end else begin
					want_v = verdicts_due.pop_front();
					note_field("header_ok", 64'(want_v.ok), 64'(got_v.ok));
					note_field("signature_bad", 64'(want_v.sig_bad), 64'(got_v.sig_bad));
					note_field("revision_bad", 64'(want_v.rev_bad), 64'(got_v.rev_bad));
					note_field("reserved_bad", 64'(want_v.rsvd_bad), 64'(got_v.rsvd_bad));
					note_field("self_lba_bad", 64'(want_v.lba_bad), 64'(got_v.lba_bad));
					note_field("trailing_bad", 64'(want_v.trail_bad), 64'(got_v.trail_bad));
					note_field("checksum_bad", 64'(want_v.crc_bad), 64'(got_v.crc_bad));
					note_field("header_length", 64'(want_v.hlen), 64'(got_v.hlen));
					note_field("entry_start_lba", want_v.elba, got_v.elba);
					note_field("entry_total", 64'(want_v.etotal), 64'(got_v.etotal));
					note_field("entry_bytes", 64'(want_v.ebytes), 64'(got_v.ebytes));
					note_field("entry_array_checksum", 64'(want_v.ecrc), 64'(got_v.ecrc));
				end
				results_seen++;
			end
		end
	end

	// Watchdog
	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_CAP) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Stimulus and end of run
	initial begin
		fault_t f;
		int     pick;
		// Directed: extreme field values
		make_header(32'd92, FLT_NONE);
		put_le(OFS_ELBA, 8, '1);
		put_le(OFS_ENUM, 4, 64'(32'hFFFF_FFFF));
		put_le(OFS_ESIZE, 4, 64'(32'hFFFF_FFFF));
		put_le(OFS_ECRC, 4, 64'(32'hFFFF_FFFF));
		seal_crc();
		queue_sector(1'b0);
		make_header(32'd92, FLT_NONE);
		put_le(OFS_ELBA, 8, 64'd0);
		put_le(OFS_ENUM, 4, 64'd0);
		put_le(OFS_ESIZE, 4, 64'd0);
		put_le(OFS_ECRC, 4, 64'd0);
		seal_crc();
		queue_sector(1'b0);
		// Directed: header sizes at the edges, short ones using the prefix CRC
		make_header(32'(SECTOR), FLT_NONE);
		queue_sector(1'b0);
		make_header(32'd0, FLT_NONE);
		queue_sector(1'b0);
		make_header(32'd15, FLT_NONE);
		queue_sector(1'b1);
		make_header(32'd16, FLT_NONE);
		queue_sector(1'b0);
		make_header(32'(SECTOR + 1), FLT_NONE);
		queue_sector(1'b0);
		make_header(32'hFFFF_FFFF, FLT_NONE);
		queue_sector(1'b0);
		// Directed: blank and all-ones sectors
		for (int i = 0; i < SECTOR; i++)
			hdr[i] = 8'h00;
		queue_sector(1'b0);
		for (int i = 0; i < SECTOR; i++)
			hdr[i] = 8'hFF;
		queue_sector(1'b0);
		// Directed: each fault on its own
		for (int k = int'(FLT_SIG); k <= int'(FLT_CRC); k++) begin
			make_header(32'd92, fault_t'(k));
			queue_sector(1'b0);
		end
		// Random: well-formed headers, faulty ones and some noise
		for (int s = 0; s < RAND_SECTS; s++) begin
			if ($urandom_range(0, 9) == 0) begin
				for (int i = 0; i < SECTOR; i++)
					hdr[i] = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 1) != 0)
					for (int i = 0; i < 8; i++)
						hdr[i] = SIG_BYTES[i];
			end else begin
				pick = $urandom_range(0, 11);
				f = (pick < 6) ? FLT_NONE : fault_t'(pick - 5);
				make_header(pick_length(), f);
			end
			queue_sector(s == 10 || s == 30);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_feed.size() != 0 || data_valid)
			@(posedge clk);
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d sectors (%0d bytes), %0d verdicts checked, %0d of them passing.",
			sectors_built, bytes_taken, results_seen, passing_due);
		$display("Input held off %0d cycles; verdicts waited on the receiver %0d cycles.",
			in_stall_cycles, out_stall_cycles);
		if (mismatches == 0 && verdicts_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ghv_pkg.sv
src/ghv_front.sv
src/ghv_queue.sv
src/ghv_back.sv
src/gpt_header_validator.sv
tb/gpt_header_validator_tb.sv
